### rtl/epfg_pkg.sv
// Package for the epoch fenced publish gate: sizes, codes, queue item type.
// Used by every module of the block but epfg_ram; no dependencies.
`default_nettype none

package epfg_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ID_BITS       = 64;

    localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXP_FMT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_OWNER = 2'd1;

    localparam logic [31:0] EXP_FMT_RESET  = 32'd1;
    localparam logic [31:0] NO_OWNER_RESET = 32'hFFFF_FFFF;

    localparam logic OP_SUBMIT  = 1'b0;
    localparam logic OP_PROMOTE = 1'b1;

    localparam logic [1:0] K_LOOKUP   = 2'd0;
    localparam logic [1:0] K_PROMOTE  = 2'd1;
    localparam logic [1:0] K_INCOMPAT = 2'd2;
    localparam logic [1:0] K_EXPIRED  = 2'd3;

    localparam logic [3:0] OUT_COMMIT    = 4'd0;
    localparam logic [3:0] OUT_SHADOW    = 4'd1;
    localparam logic [3:0] OUT_INCOMPAT  = 4'd2;
    localparam logic [3:0] OUT_EXPIRED   = 4'd3;
    localparam logic [3:0] OUT_FULL      = 4'd4;
    localparam logic [3:0] OUT_NO_OWNER  = 4'd5;
    localparam logic [3:0] OUT_STALE     = 4'd6;
    localparam logic [3:0] OUT_DUPLICATE = 4'd7;
    localparam logic [3:0] OUT_PROMOTED  = 4'd8;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ID_BITS-1:0] key;
        logic [31:0]        submitter;
        logic [63:0]        epoch;
        logic [63:0]        window;
    } q_item_t;

    typedef struct packed {
        logic                    we;
        logic [CFG_IDX_BITS-1:0] index;
        logic [31:0]             data;
    } cfg_wr_t;

    function automatic logic [3:0] idx_to_out(input logic [IDX_BITS-1:0] idx);
        logic [IDX_BITS+3:0] w;
        w = {4'b0000, idx};
        return w[3:0];
    endfunction

endpackage

`default_nettype wire

### rtl/epfg_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module epfg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/epfg_front.sv
// Front end: takes submit/promote transfers, holds the format version register,
// classifies each item for the back end. Depends on epfg_pkg.
`default_nettype none

module epfg_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire epfg_pkg::cfg_wr_t cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             opcode,
    input  wire logic             layout_ok,
    input  wire logic [31:0]      format_version,
    input  wire logic [63:0]      expiry_time,
    input  wire logic [63:0]      now_time,
    input  wire logic [63:0]      stream_id,
    input  wire logic [31:0]      submitter_id,
    input  wire logic [63:0]      submit_epoch,
    input  wire logic [63:0]      window_number,
    input  wire logic             q_full,
    output logic                  q_push,
    output epfg_pkg::q_item_t     q_item
);

    logic [31:0] exp_fmt_reg;
    logic [31:0] exp_fmt_next;

    always_comb
    begin
        exp_fmt_next = exp_fmt_reg;
        if (cfg.we && (cfg.index == epfg_pkg::CFG_EXP_FMT))
        begin
            exp_fmt_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_fmt_reg <= epfg_pkg::EXP_FMT_RESET;
        end
        else
        begin
            exp_fmt_reg <= exp_fmt_next;
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.key       = stream_id[epfg_pkg::ID_BITS-1:0];
        q_item.submitter = submitter_id;
        q_item.epoch     = submit_epoch;
        q_item.window    = window_number;
        if (opcode == epfg_pkg::OP_PROMOTE)
        begin
            q_item.kind = epfg_pkg::K_PROMOTE;
        end
        else if (!layout_ok || (format_version != exp_fmt_reg))
        begin
            q_item.kind = epfg_pkg::K_INCOMPAT;
        end
        else if ($signed(expiry_time) <= $signed(now_time))
        begin
            q_item.kind = epfg_pkg::K_EXPIRED;
        end
        else
        begin
            q_item.kind = epfg_pkg::K_LOOKUP;
        end
    end

endmodule

`default_nettype wire

### rtl/epfg_queue.sv
// Short queue of classified items between front and back end.
// Depends on epfg_pkg.
`default_nettype none

module epfg_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire epfg_pkg::q_item_t push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output epfg_pkg::q_item_t      head
);

    epfg_pkg::q_item_t slot_reg [epfg_pkg::Q_DEPTH];

    logic [epfg_pkg::Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [epfg_pkg::Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [epfg_pkg::Q_CNT_BITS-1:0] count_reg, count_next;

    assign full  = (count_reg == epfg_pkg::Q_CNT_BITS'(epfg_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    function automatic logic [epfg_pkg::Q_PTR_BITS-1:0] ptr_inc(
        input logic [epfg_pkg::Q_PTR_BITS-1:0] p);
        logic [epfg_pkg::Q_PTR_BITS-1:0] r;
        if (p == epfg_pkg::Q_PTR_BITS'(epfg_pkg::Q_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
        if (pop)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/epfg_back.sv
// Back end: stream table walk, owner/epoch fence, replay filter, result register.
// Depends on epfg_pkg and epfg_ram.
`default_nettype none

module epfg_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire epfg_pkg::cfg_wr_t       cfg,
    input  wire logic                    q_empty,
    input  wire epfg_pkg::q_item_t       q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [3:0]                   outcome,
    output logic                         index_valid,
    output logic [3:0]                   entry_index,
    output logic [63:0]                  cur_epoch
);

    localparam int IB = epfg_pkg::IDX_BITS;
    localparam int CB = epfg_pkg::CNT_BITS;
    localparam int TE = epfg_pkg::TABLE_ENTRIES;
    localparam int KB = epfg_pkg::ID_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CB-1:0] used_reg, used_next;
    logic [TE-1:0] committed_reg, committed_next;
    logic [63:0]   epoch_reg, epoch_next;
    logic [31:0]   owner_reg, owner_next;
    logic [31:0]   no_owner_reg, no_owner_next;
    logic [IB-1:0] cmp_idx_reg, cmp_idx_next;
    logic          found_reg, found_next;
    logic          out_valid_reg, out_valid_next;

    epfg_pkg::q_item_t item_reg, item_next;
    logic [IB-1:0] hit_idx_reg, hit_idx_next;
    logic [63:0]   last_win_reg, last_win_next;
    logic [3:0]    outcome_reg, outcome_next;
    logic          idx_valid_reg, idx_valid_next;
    logic [3:0]    entry_index_reg, entry_index_next;

    logic          out_free;
    logic [CB-1:0] cmp_succ;
    logic [IB-1:0] rd_addr;
    logic [KB-1:0] key_q;
    logic [63:0]   win_q;

    logic          dec_full;
    logic          dec_alloc;
    logic          dec_commit;
    logic          dec_dup;
    logic [IB-1:0] dec_idx;
    logic [3:0]    dec_outcome;
    logic          key_we;
    logic          win_we;
    logic [63:0]   win_wdata;

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign cmp_succ = CB'(cmp_idx_reg) + 1'b1;
    assign rd_addr  = (state_reg == ST_SCAN) ? cmp_succ[IB-1:0] : '0;

    // decision on the item whose table walk is done
    always_comb
    begin
        dec_full  = !found_reg && (used_reg == CB'(TE));
        dec_alloc = !found_reg && !dec_full;
        dec_idx   = found_reg ? hit_idx_reg : used_reg[IB-1:0];
        dec_dup   = found_reg && committed_reg[dec_idx]
                    && (item_reg.window <= last_win_reg);
        if (dec_full)
        begin
            dec_outcome = epfg_pkg::OUT_FULL;
        end
        else if (owner_reg == no_owner_reg)
        begin
            dec_outcome = epfg_pkg::OUT_NO_OWNER;
        end
        else if (item_reg.submitter != owner_reg)
        begin
            dec_outcome = (item_reg.epoch < epoch_reg) ? epfg_pkg::OUT_STALE
                                                       : epfg_pkg::OUT_SHADOW;
        end
        else if (item_reg.epoch != epoch_reg)
        begin
            dec_outcome = epfg_pkg::OUT_STALE;
        end
        else if (dec_dup)
        begin
            dec_outcome = epfg_pkg::OUT_DUPLICATE;
        end
        else
        begin
            dec_outcome = epfg_pkg::OUT_COMMIT;
        end
        dec_commit = !dec_full && (dec_outcome == epfg_pkg::OUT_COMMIT);
        key_we     = (state_reg == ST_DECIDE) && dec_alloc;
        win_we     = (state_reg == ST_DECIDE) && (dec_alloc || dec_commit);
        win_wdata  = dec_commit ? item_reg.window : 64'd0;
    end

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        committed_next   = committed_reg;
        epoch_next       = epoch_reg;
        owner_next       = owner_reg;
        no_owner_next    = no_owner_reg;
        cmp_idx_next     = cmp_idx_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        item_next        = item_reg;
        hit_idx_next     = hit_idx_reg;
        last_win_next    = last_win_reg;
        outcome_next     = outcome_reg;
        idx_valid_next   = idx_valid_reg;
        entry_index_next = entry_index_reg;

        if (cfg.we && (cfg.index == epfg_pkg::CFG_NO_OWNER))
        begin
            no_owner_next = cfg.data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    item_next        = q_head;
                    idx_valid_next   = 1'b0;
                    entry_index_next = 4'd0;
                    case (q_head.kind)
                        epfg_pkg::K_PROMOTE:
                        begin
                            epoch_next     = epoch_reg + 64'd1;
                            owner_next     = q_head.submitter;
                            outcome_next   = epfg_pkg::OUT_PROMOTED;
                            out_valid_next = 1'b1;
                        end
                        epfg_pkg::K_INCOMPAT:
                        begin
                            outcome_next   = epfg_pkg::OUT_INCOMPAT;
                            out_valid_next = 1'b1;
                        end
                        epfg_pkg::K_EXPIRED:
                        begin
                            outcome_next   = epfg_pkg::OUT_EXPIRED;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            cmp_idx_next = '0;
                            found_next   = 1'b0;
                            state_next   = (used_reg == '0) ? ST_DECIDE : ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (key_q == item_reg.key)
                begin
                    found_next    = 1'b1;
                    hit_idx_next  = cmp_idx_reg;
                    last_win_next = win_q;
                    state_next    = ST_DECIDE;
                end
                else if (cmp_succ == used_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmp_idx_next = cmp_succ[IB-1:0];
                end
            end
            ST_DECIDE:
            begin
                outcome_next     = dec_outcome;
                idx_valid_next   = !dec_full;
                entry_index_next = dec_full ? 4'd0 : epfg_pkg::idx_to_out(dec_idx);
                out_valid_next   = 1'b1;
                if (dec_alloc)
                begin
                    used_next               = used_reg + 1'b1;
                    committed_next[dec_idx] = 1'b0;
                end
                if (dec_commit)
                begin
                    committed_next[dec_idx] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            committed_reg <= '0;
            epoch_reg     <= '0;
            owner_reg     <= epfg_pkg::NO_OWNER_RESET;
            no_owner_reg  <= epfg_pkg::NO_OWNER_RESET;
            cmp_idx_reg   <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            committed_reg <= committed_next;
            epoch_reg     <= epoch_next;
            owner_reg     <= owner_next;
            no_owner_reg  <= no_owner_next;
            cmp_idx_reg   <= cmp_idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        hit_idx_reg     <= hit_idx_next;
        last_win_reg    <= last_win_next;
        outcome_reg     <= outcome_next;
        idx_valid_reg   <= idx_valid_next;
        entry_index_reg <= entry_index_next;
    end

    epfg_ram #(
        .WIDTH(KB),
        .DEPTH(TE)
    ) u_key_ram (
        .clk  (clk),
        .we   (key_we),
        .waddr(dec_idx),
        .wdata(item_reg.key),
        .raddr(rd_addr),
        .rdata(key_q)
    );

    epfg_ram #(
        .WIDTH(64),
        .DEPTH(TE)
    ) u_win_ram (
        .clk  (clk),
        .we   (win_we),
        .waddr(dec_idx),
        .wdata(win_wdata),
        .raddr(rd_addr),
        .rdata(win_q)
    );

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign index_valid = idx_valid_reg;
    assign entry_index = entry_index_reg;
    assign cur_epoch   = epoch_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CB'(TE))
        else $error("table fill count above table size");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (used_reg == $past(used_reg))
                 || (used_reg == $past(used_reg) + 1'b1))
        else $error("table fill count moved by more than one");

    a_decide_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> !out_valid_reg)
        else $error("decision reached with result slot occupied");

    a_commit_marks: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DECIDE) && dec_commit) |=> committed_reg[$past(dec_idx)])
        else $error("commit did not mark entry as committed");

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (q_pop == 1'b0))
        else $error("queue popped while an item is in progress");

endmodule

`default_nettype wire

### rtl/epoch_fenced_publish_gate_top.sv
// Epoch fenced publish gate: decides whether a submitted result may be
// published; owner promotion by epoch. Depends on epfg_pkg, epfg_front,
// epfg_queue, epfg_back, epfg_ram.
//
// Usage:
//   s_* carries one submit or promote item per transfer; m_* returns exactly
//   one result per item, in order. cfg_we/cfg_index/cfg_data write the format
//   version (index 0) and the no-owner code (index 1) while the block is idle.
//   Promote, incompatible and expired items pass through the queue and are
//   answered straight from the idle state. A stream lookup walks the table,
//   comparing 1 to 16 entries (none on an empty table): the walk reads one
//   key and window per cycle from the table RAMs, then a decide step
//   updates the table. Early rejects and promotes flow at one item per cycle
//   while m_tready is high; a lookup holds the back end until it is decided.
//   The front accepts up to two items into its queue while the back end works
//   or the result waits; when m_tready stays low the result holds, the queue
//   fills and s_tready drops.
//   Reset (rst_n low, asynchronous) empties the table and queue, sets the
//   epoch to zero and the owner to the no-owner code; no clearing pass.
`default_nettype none

module epoch_fenced_publish_gate_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // format_version[31:0], expiry_time[95:32], now_time[159:96],
    // stream_id[223:160], submitter_id[255:224], submit_epoch[319:256],
    // window_number[383:320]
    input  wire logic [383:0]                      s_tdata,
    // opcode[0], layout_ok[1]
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // entry_index[3:0], cur_epoch[67:4], zero[71:68]
    output logic [71:0]                            m_tdata,
    // outcome[3:0], index_valid[4]
    output logic [4:0]                             m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [epfg_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    epfg_pkg::cfg_wr_t cfg;
    epfg_pkg::q_item_t push_item;
    epfg_pkg::q_item_t q_head;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [3:0]        outcome;
    logic              index_valid;
    logic [3:0]        entry_index;
    logic [63:0]       cur_epoch;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    epfg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .opcode        (s_tuser[0]),
        .layout_ok     (s_tuser[1]),
        .format_version(s_tdata[31:0]),
        .expiry_time   (s_tdata[95:32]),
        .now_time      (s_tdata[159:96]),
        .stream_id     (s_tdata[223:160]),
        .submitter_id  (s_tdata[255:224]),
        .submit_epoch  (s_tdata[319:256]),
        .window_number (s_tdata[383:320]),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    epfg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_item(push_item),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    epfg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .outcome    (outcome),
        .index_valid(index_valid),
        .entry_index(entry_index),
        .cur_epoch  (cur_epoch)
    );

    assign m_tdata = {4'b0000, cur_epoch, entry_index};
    assign m_tuser = {index_valid, outcome};

endmodule

`default_nettype wire
